### rtl/core/rtpm_pkg.sv
// shared types, codes and constants of the route table prefix match unit
`timescale 1ns / 1ps

package rtpm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int OP_W   = 3;
    localparam int SLOT_W = 8;
    localparam int ADDR_W = 32;
    localparam int COST_W = 5;
    localparam int STAT_W = 2;
    localparam int PLEN_W = 6;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = SLOT_W + 3 * ADDR_W + COST_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + 3 * ADDR_W + COST_W + PLEN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // first slot index that is out of range
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(TABLE_DEPTH);
    // last valid scan count
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // one stored route, subnet in the lowest bits
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] subnet;
    } t_route;

    localparam int ROUTE_W = $bits(t_route);

    // ones count of a 32-bit mask as a shallow adder tree
    function automatic logic [PLEN_W-1:0] popcount32(input logic [31:0] v);
        logic [31:0] x;
        x = v - ((v >> 1) & 32'h5555_5555);
        x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
        x = (x + (x >> 4)) & 32'h0f0f_0f0f;
        x = x + (x >> 8);
        x = x + (x >> 16);
        return x[PLEN_W-1:0];
    endfunction

endpackage

### rtl/core/route_table_prefix_match_unit.sv
// route table with add, remove, get, exact find and longest prefix lookup
`timescale 1ns / 1ps

// The table holds TABLE_DEPTH routes (subnet, mask, next hop, metric) in one
// ram with a registered read port; the valid bits sit in flip-flops and are
// cleared by reset, so the table is empty straight after reset. The unit works
// on one request at a time and is not ready while busy. Find and lookup walk
// every slot through the single ram read port and one shared compare and
// ones-count stage. Add walks the valid bits up to the first empty slot; get
// and remove read the slot through the ram, and out-of-range, empty-slot or
// unknown requests go straight to the result. The unit is ready again in the
// cycle the result appears. An output register holds the result, so a new
// request can be taken while the previous result still waits for the sink.

module route_table_prefix_match_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // slot_index, address, net_mask, gateway, cost (lowest bit up)
    input  logic [rtpm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // operation
    input  logic [rtpm_pkg::OP_W-1:0]        i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // slot, route_subnet, route_mask, route_gateway, route_cost,
    // match_len (lowest bit up)
    output logic [rtpm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // status
    output logic [rtpm_pkg::STAT_W-1:0]      o_m_axis_tuser
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam int IW = rtpm_pkg::IDX_W;
    localparam int CW = rtpm_pkg::CNT_W;

    logic [2:0]                         r_state, n_state;
    logic [rtpm_pkg::OP_W-1:0]          r_op, n_op;
    logic [IW-1:0]                      r_idx, n_idx;
    rtpm_pkg::t_route                   r_req, n_req;
    logic [CW-1:0]                      r_cnt, n_cnt;
    logic                               r_rd_vld, n_rd_vld;
    logic [IW-1:0]                      r_rd_idx, n_rd_idx;
    logic [rtpm_pkg::TABLE_DEPTH-1:0]   r_valid, n_valid;
    logic                               r_hit, n_hit;
    logic [rtpm_pkg::STAT_W-1:0]        r_res_status, n_res_status;
    logic [rtpm_pkg::SLOT_W-1:0]        r_res_slot, n_res_slot;
    rtpm_pkg::t_route                   r_res_route, n_res_route;
    logic [rtpm_pkg::PLEN_W-1:0]        r_res_plen, n_res_plen;
    logic                               r_out_valid, n_out_valid;
    logic [rtpm_pkg::STAT_W-1:0]        r_out_status, n_out_status;
    logic [rtpm_pkg::OUT_DATA_W-1:0]    r_out_data, n_out_data;

    logic                               in_xfer;
    logic [rtpm_pkg::SLOT_W-1:0]        in_slot;
    logic                               ram_we;
    logic [IW-1:0]                      ram_raddr;
    rtpm_pkg::t_route                   ram_rdata;
    logic [IW-1:0]                      cnt_idx;
    logic                               find_hit;
    logic                               lkup_hit;
    logic [rtpm_pkg::PLEN_W-1:0]        cur_len;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign in_slot = i_s_axis_tdata[rtpm_pkg::SLOT_W-1:0];
    assign cnt_idx = r_cnt[IW-1:0];

    // route table storage
    rtpm_ram #(
        .WIDTH (rtpm_pkg::ROUTE_W),
        .DEPTH (rtpm_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_idx),
        .i_wdata (r_req),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare stage on the entry just read
    always_comb begin
        find_hit = r_valid[r_rd_idx] && (ram_rdata.subnet == r_req.subnet)
                   && (ram_rdata.mask == r_req.mask);
        lkup_hit = r_valid[r_rd_idx]
                   && ((r_req.subnet & ram_rdata.mask) == ram_rdata.subnet);
        cur_len  = rtpm_pkg::popcount32(ram_rdata.mask);
    end

    // sequencer and datapath next state
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_req        = r_req;
        n_cnt        = r_cnt;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_valid      = r_valid;
        n_hit        = r_hit;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_route  = r_res_route;
        n_res_plen   = r_res_plen;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_raddr    = cnt_idx;

        // result leaves the output register
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op         = i_s_axis_tuser;
                    n_idx        = in_slot[IW-1:0];
                    n_req        = i_s_axis_tdata[rtpm_pkg::SLOT_W +: rtpm_pkg::ROUTE_W];
                    n_cnt        = '0;
                    n_rd_vld     = 1'b0;
                    n_hit        = 1'b0;
                    n_res_status = rtpm_pkg::ST_NONE;
                    n_res_slot   = '0;
                    n_res_route  = '0;
                    n_res_plen   = '0;
                    case (i_s_axis_tuser)
                        rtpm_pkg::OP_ADD: begin
                            n_state = S_ADD;
                        end
                        rtpm_pkg::OP_REMOVE, rtpm_pkg::OP_GET: begin
                            if ({1'b0, in_slot} >= rtpm_pkg::SLOT_LIMIT) begin
                                n_res_status = rtpm_pkg::ST_RANGE;
                                n_state      = S_FIN;
                            end else if (!r_valid[in_slot[IW-1:0]]) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        rtpm_pkg::OP_FIND, rtpm_pkg::OP_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // walk the valid bits up to the first empty slot
            S_ADD: begin
                if (!r_valid[cnt_idx]) begin
                    ram_we           = 1'b1;
                    n_valid[cnt_idx] = 1'b1;
                    n_res_status     = rtpm_pkg::ST_OK;
                    n_res_slot       = rtpm_pkg::SLOT_W'(cnt_idx);
                    n_res_route      = r_req;
                    n_state          = S_FIN;
                end else if (r_cnt == rtpm_pkg::CNT_LAST) begin
                    n_res_status = rtpm_pkg::ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            // one slot read per cycle, compared in the cycle after
            S_SCAN: begin
                if (r_cnt != rtpm_pkg::CNT_END) begin
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = cnt_idx;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_op == rtpm_pkg::OP_FIND) begin
                        if (find_hit && !r_hit) begin
                            n_hit        = 1'b1;
                            n_res_status = rtpm_pkg::ST_OK;
                            n_res_slot   = rtpm_pkg::SLOT_W'(r_rd_idx);
                            n_res_route  = ram_rdata;
                        end
                    end else begin
                        // strictly longer wins, so the earliest slot keeps a tie
                        if (lkup_hit && (!r_hit || (cur_len > r_res_plen))) begin
                            n_hit        = 1'b1;
                            n_res_status = rtpm_pkg::ST_OK;
                            n_res_slot   = rtpm_pkg::SLOT_W'(r_rd_idx);
                            n_res_route  = ram_rdata;
                            n_res_plen   = cur_len;
                        end
                    end
                end
                if ((r_cnt == rtpm_pkg::CNT_END) && !r_rd_vld) begin
                    n_state = S_FIN;
                end
            end

            // get or remove of a valid slot
            S_READ: begin
                ram_raddr = r_idx;
                n_state   = S_RDATA;
            end

            S_RDATA: begin
                n_res_status = rtpm_pkg::ST_OK;
                n_res_slot   = rtpm_pkg::SLOT_W'(r_idx);
                n_res_route  = ram_rdata;
                if (r_op == rtpm_pkg::OP_REMOVE) begin
                    n_valid[r_idx] = 1'b0;
                end
                n_state = S_FIN;
            end

            // hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = {{rtpm_pkg::OUT_PAD_W{1'b0}}, r_res_plen,
                                    r_res_route, r_res_slot};
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_req        <= n_req;
        r_cnt        <= n_cnt;
        r_rd_idx     <= n_rd_idx;
        r_hit        <= n_hit;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_route  <= n_res_route;
        r_res_plen   <= n_res_plen;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

### rtl/core/rtpm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rtpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rtpm_checker.sv
// port-level checks of the route table prefix match unit and their binding
`timescale 1ns / 1ps

module rtpm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             o_s_axis_tready,
    input  logic [rtpm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [rtpm_pkg::OP_W-1:0]        i_s_axis_tuser,
    input  logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic [rtpm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic [rtpm_pkg::STAT_W-1:0]      o_m_axis_tuser
);

    localparam int PLEN_LO = rtpm_pkg::SLOT_W + rtpm_pkg::ROUTE_W;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // the unit is busy the cycle after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while busy");

    // failed requests carry no slot, route or prefix length
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != rtpm_pkg::ST_OK) |->
            (o_m_axis_tdata == '0))
        else $error("non-zero payload on failed result");

    // prefix length never exceeds the address width
    a_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[PLEN_LO +: rtpm_pkg::PLEN_W] <= rtpm_pkg::PLEN_W'(32)))
        else $error("prefix length out of range");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind route_table_prefix_match_unit rtpm_checker u_rtpm_checker (.*);

### tb/tb.sv
// self-checking testbench for the route table prefix match unit
`timescale 1ns / 1ps

module tb;
    import rtpm_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RESET_CYCLES   = 7;
    localparam int OP_RESERVED_LO = 5;
    localparam int OP_RESERVED_HI = 7;

    // request fields as packed into tdata, slot_index in the lowest bits
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] net_mask;
        logic [ADDR_W-1:0] address;
        logic [SLOT_W-1:0] slot_index;
    } req_fields_t;

    // result fields as packed into tdata, slot in the lowest bits
    typedef struct packed {
        logic [PLEN_W-1:0] match_len;
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] subnet;
        logic [SLOT_W-1:0] slot;
    } route_reply_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        route_reply_t      reply;
    } route_outcome_t;

    // operation mix of one stretch of random traffic
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_LOOKUP} op_mix_t;

    // mirror of the route table and the queue of outcomes still owed
    class route_table_scoreboard;
        bit             live [TABLE_DEPTH];
        t_route         routes [TABLE_DEPTH];
        route_outcome_t owed_results [$];
        int             error_count;

        function new();
            error_count = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function int prefix_ones(logic [ADDR_W-1:0] mask);
            int n;
            n = 0;
            for (int b = 0; b < ADDR_W; b++) n += mask[b];
            return n;
        endfunction

        function route_reply_t slot_reply(int s, int plen);
            route_reply_t r;
            r.slot      = SLOT_W'(s);
            r.subnet    = routes[s].subnet;
            r.mask      = routes[s].mask;
            r.gateway   = routes[s].gateway;
            r.cost      = routes[s].cost;
            r.match_len = PLEN_W'(plen);
            return r;
        endfunction

        // random occupied slot, or -1 when the table is empty
        function int live_slot();
            int taken [$];
            foreach (live[i]) if (live[i]) taken.push_back(i);
            if (taken.size() == 0) return -1;
            return taken[$urandom_range(0, taken.size() - 1)];
        endfunction

        // apply one accepted request to the mirror and queue its outcome
        function void note_request(logic [OP_W-1:0] op, req_fields_t req);
            route_outcome_t outcome;
            int best;
            int best_len;
            int len;
            outcome.status = ST_NONE;
            outcome.reply  = '0;
            best     = -1;
            best_len = 0;
            case (op)
                OP_ADD: begin
                    outcome.status = ST_FULL;
                    for (int s = 0; s < TABLE_DEPTH; s++) begin
                        if (!live[s]) begin
                            live[s]            = 1'b1;
                            routes[s].subnet   = req.address;
                            routes[s].mask     = req.net_mask;
                            routes[s].gateway  = req.gateway;
                            routes[s].cost     = req.cost;
                            outcome.status     = ST_OK;
                            outcome.reply      = slot_reply(s, 0);
                            break;
                        end
                    end
                end
                OP_REMOVE, OP_GET: begin
                    if (req.slot_index >= TABLE_DEPTH) begin
                        outcome.status = ST_RANGE;
                    end else if (live[req.slot_index]) begin
                        outcome.status = ST_OK;
                        outcome.reply  = slot_reply(req.slot_index, 0);
                        if (op == OP_REMOVE) live[req.slot_index] = 1'b0;
                    end
                end
                OP_FIND: begin
                    for (int s = 0; s < TABLE_DEPTH; s++) begin
                        if (live[s] && routes[s].subnet == req.address
                                && routes[s].mask == req.net_mask) begin
                            outcome.status = ST_OK;
                            outcome.reply  = slot_reply(s, 0);
                            break;
                        end
                    end
                end
                OP_LOOKUP: begin
                    // longest prefix wins, earliest slot on a tie
                    for (int s = 0; s < TABLE_DEPTH; s++) begin
                        if (live[s] && (req.address & routes[s].mask) == routes[s].subnet) begin
                            len = prefix_ones(routes[s].mask);
                            if (best < 0 || len > best_len) begin
                                best     = s;
                                best_len = len;
                            end
                        end
                    end
                    if (best >= 0) begin
                        outcome.status = ST_OK;
                        outcome.reply  = slot_reply(best, best_len);
                    end
                end
                default: ;
            endcase
            owed_results.push_back(outcome);
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                error_count++;
            end
        endfunction

        // compare one result transfer against the oldest owed outcome
        function void check_result(logic [STAT_W-1:0] status, route_reply_t got);
            route_outcome_t want;
            if (owed_results.size() == 0) begin
                $error("result transfer with no request outstanding, status %0d", status);
                error_count++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", want.status, status);
            compare_field("slot", want.reply.slot, got.slot);
            compare_field("route_subnet", want.reply.subnet, got.subnet);
            compare_field("route_mask", want.reply.mask, got.mask);
            compare_field("route_gateway", want.reply.gateway, got.gateway);
            compare_field("route_cost", want.reply.cost, got.cost);
            compare_field("match_len", want.reply.match_len, got.match_len);
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;
    logic                  steady_run    = 1'b0;
    int                    cycle_count   = 0;

    route_table_scoreboard sb = new();

    route_table_prefix_match_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, route_reply_t'(m_axis_tdata[OUT_FIELDS_W-1:0]));
    end

    // mostly short gaps, now and then a long one, none during a steady run
    function automatic int pick_gap();
        int r;
        if (steady_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // sink back-pressure
    initial begin : sink_pacing
        int run_len;
        int stall_len;
        forever begin
            run_len = $urandom_range(1, 40);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    function automatic req_fields_t make_req(int idx, logic [ADDR_W-1:0] addr,
            logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] gw, int cost);
        req_fields_t req;
        req.slot_index = SLOT_W'(idx);
        req.address    = addr;
        req.net_mask   = mask;
        req.gateway    = gw;
        req.cost       = COST_W'(cost);
        return req;
    endfunction

    // mostly contiguous prefixes, sometimes arbitrary bit patterns
    function automatic logic [ADDR_W-1:0] make_mask();
        int len;
        if ($urandom_range(0, 9) < 2) return $urandom();
        len = $urandom_range(0, ADDR_W);
        return (len == 0) ? '0 : ~32'h0 << (ADDR_W - len);
    endfunction

    // addresses clustered around a few networks so that prefixes overlap
    function automatic logic [ADDR_W-1:0] near_address();
        logic [ADDR_W-1:0] base;
        case ($urandom_range(0, 3))
            0:       base = 32'h0A00_0000;
            1:       base = 32'hC0A8_0100;
            2:       base = 32'hAC10_0000;
            default: base = 32'hFFFF_FF00;
        endcase
        return base ^ ($urandom() >> $urandom_range(4, 31));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
        int r;
        int add_w;
        int rem_w;
        int get_w;
        int find_w;
        case (mix)
            MIX_FILL:  begin add_w = 60; rem_w = 5;  get_w = 10; find_w = 10; end
            MIX_DRAIN: begin add_w = 15; rem_w = 40; get_w = 15; find_w = 12; end
            MIX_LOOKUP: begin add_w = 20; rem_w = 10; get_w = 10; find_w = 15; end
            default:   begin add_w = 30; rem_w = 20; get_w = 15; find_w = 15; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 3) return OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        r -= 3;
        if (r < add_w) return OP_ADD;
        r -= add_w;
        if (r < rem_w) return OP_REMOVE;
        r -= rem_w;
        if (r < get_w) return OP_GET;
        r -= get_w;
        if (r < find_w) return OP_FIND;
        return OP_LOOKUP;
    endfunction

    // one request transfer, noted in the scoreboard when accepted
    task automatic send_request(input logic [OP_W-1:0] op, input req_fields_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(req);
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, req);
    endtask

    // random request shaped after the current table contents
    task automatic issue_random(input op_mix_t mix);
        logic [OP_W-1:0] op;
        req_fields_t     req;
        int              s;
        op = pick_op(mix);
        req.slot_index = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 255))
                                                     : SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
        req.address  = $urandom();
        req.net_mask = $urandom();
        req.gateway  = $urandom();
        req.cost     = ($urandom_range(0, 4) == 0) ? COST_W'($urandom())
                                                   : COST_W'($urandom_range(0, 16));
        s = sb.live_slot();
        case (op)
            OP_ADD: begin
                req.net_mask = make_mask();
                req.address  = near_address();
                // now and then keep subnet bits outside the mask
                if ($urandom_range(0, 6) != 0) req.address &= req.net_mask;
            end
            OP_FIND: begin
                if (s >= 0 && $urandom_range(0, 9) < 7) begin
                    req.address  = sb.routes[s].subnet;
                    req.net_mask = sb.routes[s].mask;
                end else begin
                    req.net_mask = make_mask();
                    req.address  = near_address() & req.net_mask;
                end
            end
            OP_LOOKUP: begin
                if (s >= 0 && $urandom_range(0, 9) < 6)
                    req.address = sb.routes[s].subnet | (req.address & ~sb.routes[s].mask);
                else if ($urandom_range(0, 1) == 0)
                    req.address = near_address();
            end
            OP_REMOVE, OP_GET: begin
                if (s >= 0 && $urandom_range(0, 1) == 0) req.slot_index = SLOT_W'(s);
            end
            default: ;
        endcase
        send_request(op, req);
    endtask

    // reset, directed requests, random traffic, then wait for the last result
    initial begin : stimulus
        int      produced;
        int      seg_len;
        op_mix_t mix;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, out of range indexes and unknown operations
        send_request(OP_LOOKUP, make_req(0, 32'h0A01_0203, '0, '0, 0));
        send_request(OP_GET,    make_req(0, '0, '0, '0, 0));
        send_request(OP_REMOVE, make_req(TABLE_DEPTH - 1, '0, '0, '0, 0));
        send_request(OP_GET,    make_req(TABLE_DEPTH, '0, '0, '0, 0));
        send_request(OP_REMOVE, make_req(255, '1, '1, '1, 31));
        for (int k = OP_RESERVED_LO; k <= OP_RESERVED_HI; k++)
            send_request(OP_W'(k), make_req(255, '1, '1, '1, 31));
        send_request(OP_FIND,   make_req(0, '0, '0, '0, 0));

        // default route, host route, nested prefixes, a duplicate, stray subnet bits
        send_request(OP_ADD, make_req(0, 32'h0, 32'h0, 32'h0102_0304, 0));
        send_request(OP_ADD, make_req(0, '1, '1, '1, 31));
        send_request(OP_ADD, make_req(0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 16));
        send_request(OP_ADD, make_req(0, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 1));
        send_request(OP_ADD, make_req(0, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0002, 2));
        send_request(OP_ADD, make_req(0, 32'h0A01_0101, 32'hFFFF_0000, 32'h0A01_0003, 3));
        send_request(OP_LOOKUP, make_req(0, 32'h0A01_0203, '0, '0, 0));
        send_request(OP_LOOKUP, make_req(0, 32'h0B00_0000, '0, '0, 0));
        send_request(OP_LOOKUP, make_req(0, '1, '0, '0, 0));
        send_request(OP_FIND,   make_req(0, 32'h0A01_0101, 32'hFFFF_0000, '0, 0));
        send_request(OP_FIND,   make_req(0, 32'h0A01_0000, 32'hFFFF_FF00, '0, 0));

        // remove the first of a tie, then the second must win
        send_request(OP_REMOVE, make_req(3, '0, '0, '0, 0));
        send_request(OP_REMOVE, make_req(3, '0, '0, '0, 0));
        send_request(OP_LOOKUP, make_req(0, 32'h0A01_0203, '0, '0, 0));
        send_request(OP_GET,    make_req(4, '0, '0, '0, 0));
        send_request(OP_ADD,    make_req(0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 5));

        // random traffic in stretches; the first one uses the fill mix
        produced = 0;
        mix      = MIX_FILL;
        while (produced < RANDOM_ITEMS) begin
            seg_len    = $urandom_range(60, 120);
            steady_run = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && produced < RANDOM_ITEMS; k++) begin
                issue_random(mix);
                produced++;
            end
            mix = op_mix_t'($urandom_range(0, 3));
        end
        s_axis_tvalid <= 1'b0;
        steady_run    = 1'b0;

        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### route_table_prefix_match_unit.f
rtl/core/rtpm_pkg.sv
rtl/core/rtpm_ram.sv
rtl/core/route_table_prefix_match_unit.sv
rtl/core/rtpm_checker.sv
tb/tb.sv
